/* sv/per_client_rate_limiter_with_block_top_assert.svh */
// Assertion macros used by the checker file of the rate limiter.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef PER_CLIENT_RATE_LIMITER_WITH_BLOCK_TOP_ASSERT_SVH
`define PER_CLIENT_RATE_LIMITER_WITH_BLOCK_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PCRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pcrl_pkg.sv */
// Shared types and constants of the per-client rate limiter.
// Used by the top level and the RAM sizing; depends on nothing.
`default_nettype none

package pcrl_pkg;

  localparam int unsigned CLIENTS_DEF = 256;

  localparam int unsigned COUNT_W = 21;
  localparam int unsigned OUT_W   = 9;
  localparam int unsigned CFG_W   = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [31:0]        YEAR_SECONDS = 32'd31536000;

  // Request codes.
  localparam logic [2:0] REQ_EVENT     = 3'd0;
  localparam logic [2:0] REQ_BLOCK     = 3'd1;
  localparam logic [2:0] REQ_UNBLOCK   = 3'd2;
  localparam logic [2:0] REQ_SWEEP     = 3'd3;
  localparam logic [2:0] REQ_BLOCK_ALL = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_EVENTS = 2'd0;
  localparam logic [1:0] CFG_WINDOW     = 2'd1;
  localparam logic [1:0] CFG_PENALTY    = 2'd2;

  // Configuration reset values.
  localparam logic [19:0] MAX_EVENTS_RST = 20'd100;
  localparam logic [23:0] WINDOW_RST     = 24'd60;
  localparam logic [23:0] PENALTY_RST    = 24'd300;

  // One table entry as held in the RAM. An absent entry is all zero.
  typedef struct packed {
    logic               valid;
    logic               blocked;
    logic [COUNT_W-1:0] event_count;
    logic [31:0]        window_start;
    logic [31:0]        block_until;
  } entry_t;

endpackage

`default_nettype wire

/* sv/per_client_rate_limiter_with_block_top.sv */
// Channel     | Direction | Handshake               | Beat contents
// in          | sink      | in_valid_i / in_stall_o | req_type, client, now_time, hold_seconds
// out         | source    | out_valid_o/out_stall_i | accepted, unblocked/removed/blocked counts
// cfg         | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// After reset the block walks the table once to clear it, with in_stall_o high. An event
// runs RD, LIFT, WADD, WCMP, WR, FIN; a held client's event and a block or unblock skip WADD
// and WCMP, an unblock of an absent entry runs RD, LIFT, FIN and a reserved code FIN alone.
// Every time sum and time compare goes through one 34-bit adder. A sweep takes each valid
// entry through RD..WR (skipping WADD, WCMP if held), a block-all through RD, LIFT, WR; both
// run absent ones via RD, LIFT, then FIN. A stalled output delays only the next item's end.
//
// Depends on pcrl_pkg and pcrl_ram.
`default_nettype none

module per_client_rate_limiter_with_block_top #(
  parameter int unsigned CLIENTS = pcrl_pkg::CLIENTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  client_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic [31:0] hold_seconds_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic [8:0]       unblocked_count_o,
  output logic [8:0]       removed_count_o,
  output logic [8:0]       blocked_count_o
);

  localparam int unsigned AW = $clog2(CLIENTS);
  localparam int unsigned EW = $bits(pcrl_pkg::entry_t);
  localparam int unsigned UW = 34;

  // Sequencer states. The table sweep and block-all reuse RD..WR per entry.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_LIFT  = 3'd3;
  localparam logic [2:0] ST_WADD  = 3'd4;
  localparam logic [2:0] ST_WCMP  = 3'd5;
  localparam logic [2:0] ST_WR    = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  // Configuration registers.
  logic [19:0] max_q;
  logic [23:0] win_q;
  logic [23:0] pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= pcrl_pkg::MAX_EVENTS_RST;
      win_q <= pcrl_pkg::WINDOW_RST;
      pen_q <= pcrl_pkg::PENALTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcrl_pkg::CFG_MAX_EVENTS: max_q <= cfg_data_i[19:0];
        pcrl_pkg::CFG_WINDOW:     win_q <= cfg_data_i;
        pcrl_pkg::CFG_PENALTY:    pen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [2:0]    st_q, st_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;

  // Request and working registers (payload, no reset).
  logic [2:0]           req_q, req_d;
  logic [7:0]           client_q, client_d;
  logic [31:0]          now_q, now_d;
  logic [31:0]          hold_q, hold_d;
  pcrl_pkg::entry_t     ent_q, ent_d;
  logic [31:0]          exp_q, exp_d;
  logic [UW-1:0]        thr_q, thr_d;
  logic                 acc_q, acc_d;
  logic [8:0]           unb_q, unb_d;
  logic [8:0]           rem_q, rem_d;
  logic [8:0]           blk_q, blk_d;
  logic                 acc_out_q, acc_out_d;
  logic [8:0]           unb_out_q, unb_out_d;
  logic [8:0]           rem_out_q, rem_out_d;
  logic [8:0]           blk_out_q, blk_out_d;

  // RAM port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  pcrl_pkg::entry_t     ram_wdata;
  pcrl_pkg::entry_t     ram_rdata;

  // Shared adder/comparator. For a subtract the carry out says a >= b.
  logic [UW-1:0] op_a, op_b;
  logic          op_sub;
  logic [UW:0]   unit_sum;
  logic          unit_ge;
  logic [31:0]   unit_sat;

  assign unit_sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (UW+1)'(op_sub);
  assign unit_ge  = unit_sum[UW];
  assign unit_sat = (|unit_sum[UW-1:32]) ? '1 : unit_sum[31:0];

  logic loop_req;
  logic last_idx;
  logic in_range;
  logic in_fire;

  assign loop_req = (req_q == pcrl_pkg::REQ_SWEEP) || (req_q == pcrl_pkg::REQ_BLOCK_ALL);
  assign last_idx = (idx_q == AW'(CLIENTS - 1));
  assign in_range = (32'(client_i) < CLIENTS);
  assign in_fire  = in_valid_i && !in_stall_o;
  assign ram_addr = (loop_req || st_q == ST_CLEAR) ? idx_q : AW'(client_q);

  // Window restart decision and the event counter update.
  logic                        restart;
  logic [pcrl_pkg::COUNT_W-1:0] cnt_base;
  logic [pcrl_pkg::COUNT_W-1:0] cnt_inc;

  assign restart  = (win_q == '0) || unit_ge;
  assign cnt_base = restart ? '0 : ent_q.event_count;
  assign cnt_inc  = (cnt_base == pcrl_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

  logic [31:0] addend;

  always_comb begin
    case (req_q)
      pcrl_pkg::REQ_BLOCK:     addend = hold_q;
      pcrl_pkg::REQ_BLOCK_ALL: addend = pcrl_pkg::YEAR_SECONDS;
      default:                 addend = {8'd0, pen_q};
    endcase
  end

  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    req_d       = req_q;
    client_d    = client_q;
    now_d       = now_q;
    hold_d      = hold_q;
    ent_d       = ent_q;
    exp_d       = exp_q;
    thr_d       = thr_q;
    acc_d       = acc_q;
    unb_d       = unb_q;
    rem_d       = rem_q;
    blk_d       = blk_q;
    acc_out_d   = acc_out_q;
    unb_out_d   = unb_out_q;
    rem_out_d   = rem_out_q;
    blk_out_d   = blk_out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_wdata   = ent_q;
    op_a        = {2'b00, now_q};
    op_b        = {2'b00, addend};
    op_sub      = 1'b0;

    unique case (st_q)
      ST_CLEAR: begin
        // Zero every entry once after reset.
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_d     = idx_q + 1'b1;
        if (last_idx) begin
          st_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          req_d    = req_type_i;
          client_d = client_i;
          now_d    = now_time_i;
          hold_d   = hold_seconds_i;
          idx_d    = '0;
          acc_d    = 1'b0;
          unb_d    = '0;
          rem_d    = '0;
          blk_d    = '0;
          case (req_type_i) inside
            pcrl_pkg::REQ_EVENT, pcrl_pkg::REQ_BLOCK, pcrl_pkg::REQ_UNBLOCK:
              st_d = in_range ? ST_RD : ST_FIN;
            pcrl_pkg::REQ_SWEEP, pcrl_pkg::REQ_BLOCK_ALL:
              st_d = ST_RD;
            default:
              st_d = ST_FIN;
          endcase
        end
      end

      ST_RD: begin
        // The read is in flight; meanwhile the unit forms the saturated expiry.
        exp_d = unit_sat;
        st_d  = ST_LIFT;
      end

      ST_LIFT: begin
        op_b   = {2'b00, ram_rdata.block_until};
        op_sub = 1'b1;
        ent_d  = ram_rdata;
        st_d   = ST_WR;
        case (req_q)
          pcrl_pkg::REQ_EVENT: begin
            ent_d.valid = 1'b1;
            if (ram_rdata.blocked && unit_ge) begin
              ent_d.blocked      = 1'b0;
              ent_d.event_count  = '0;
              ent_d.window_start = now_q;
              st_d               = ST_WADD;
            end else if (!ram_rdata.blocked) begin
              st_d = ST_WADD;
            end
          end
          pcrl_pkg::REQ_BLOCK: begin
            ent_d.valid       = 1'b1;
            ent_d.blocked     = 1'b1;
            ent_d.block_until = exp_q;
          end
          pcrl_pkg::REQ_UNBLOCK: begin
            if (ram_rdata.valid) begin
              ent_d.blocked      = 1'b0;
              ent_d.event_count  = '0;
              ent_d.window_start = now_q;
            end else begin
              st_d = ST_FIN;
            end
          end
          pcrl_pkg::REQ_SWEEP: begin
            if (!ram_rdata.valid) begin
              if (last_idx) begin
                st_d = ST_FIN;
              end else begin
                idx_d = idx_q + 1'b1;
                st_d  = ST_RD;
              end
            end else if (ram_rdata.blocked && unit_ge) begin
              ent_d.blocked      = 1'b0;
              ent_d.event_count  = '0;
              ent_d.window_start = now_q;
              if (unb_q != '1) begin
                unb_d = unb_q + 1'b1;
              end
              st_d = ST_WADD;
            end else if (!ram_rdata.blocked) begin
              st_d = ST_WADD;
            end
          end
          default: begin
            // Block-all.
            if (!ram_rdata.valid) begin
              if (last_idx) begin
                st_d = ST_FIN;
              end else begin
                idx_d = idx_q + 1'b1;
                st_d  = ST_RD;
              end
            end else begin
              ent_d.blocked     = 1'b1;
              ent_d.block_until = exp_q;
              if (blk_q != '1) begin
                blk_d = blk_q + 1'b1;
              end
            end
          end
        endcase
      end

      ST_WADD: begin
        // Window end: start plus one window, or two for the stale check.
        op_a  = {2'b00, ent_q.window_start};
        op_b  = (req_q == pcrl_pkg::REQ_SWEEP) ? {9'd0, win_q, 1'b0} : {10'd0, win_q};
        thr_d = unit_sum[UW-1:0];
        st_d  = ST_WCMP;
      end

      ST_WCMP: begin
        op_b   = thr_q;
        op_sub = 1'b1;
        st_d   = ST_WR;
        if (req_q == pcrl_pkg::REQ_SWEEP) begin
          if (restart) begin
            ent_d = '0;
            if (rem_q != '1) begin
              rem_d = rem_q + 1'b1;
            end
          end
        end else begin
          if (restart) begin
            ent_d.window_start = now_q;
          end
          ent_d.event_count = cnt_inc;
          if (cnt_inc > pcrl_pkg::COUNT_W'(max_q)) begin
            ent_d.blocked     = 1'b1;
            ent_d.block_until = exp_q;
          end else begin
            acc_d = 1'b1;
          end
        end
      end

      ST_WR: begin
        ram_we = 1'b1;
        if (loop_req && !last_idx) begin
          idx_d = idx_q + 1'b1;
          st_d  = ST_RD;
        end else begin
          st_d = ST_FIN;
        end
      end

      ST_FIN: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          acc_out_d   = acc_q;
          unb_out_d   = unb_q;
          rem_out_d   = rem_q;
          blk_out_d   = blk_q;
          st_d        = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    client_q  <= client_d;
    now_q     <= now_d;
    hold_q    <= hold_d;
    ent_q     <= ent_d;
    exp_q     <= exp_d;
    thr_q     <= thr_d;
    acc_q     <= acc_d;
    unb_q     <= unb_d;
    rem_q     <= rem_d;
    blk_q     <= blk_d;
    acc_out_q <= acc_out_d;
    unb_out_q <= unb_out_d;
    rem_out_q <= rem_out_d;
    blk_out_q <= blk_out_d;
  end

  pcrl_ram #(
    .WIDTH (EW),
    .DEPTH (CLIENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o        = (st_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_out_q;
  assign unblocked_count_o = unb_out_q;
  assign removed_count_o   = rem_out_q;
  assign blocked_count_o   = blk_out_q;

endmodule

`default_nettype wire

/* sv/pcrl_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module pcrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/pcrl_checker.sv */
// Port-level checks of the rate limiter, bound to its top level.
// Depends on the assertion macros header.
`default_nettype none

`include "per_client_rate_limiter_with_block_top_assert.svh"

module pcrl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       accepted_o,
  input wire logic [8:0] unblocked_count_o,
  input wire logic [8:0] removed_count_o,
  input wire logic [8:0] blocked_count_o
);

  `PCRL_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o, "out beat dropped while stalled")
  `PCRL_ASSERT_NEXT(a_out_beat_stable, out_valid_o && out_stall_i, $stable(accepted_o) && $stable(blocked_count_o), "stalled out beat changed")
  `PCRL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "second in beat taken while busy")
  `PCRL_ASSERT_NOW(a_event_only, out_valid_o && accepted_o, unblocked_count_o == 9'd0 && removed_count_o == 9'd0 && blocked_count_o == 9'd0, "accepted event carries table counts")
  `PCRL_ASSERT_NOW(a_block_all_only, out_valid_o && blocked_count_o != 9'd0, unblocked_count_o == 9'd0 && removed_count_o == 9'd0, "block-all beat carries sweep counts")

endmodule

bind per_client_rate_limiter_with_block_top pcrl_checker u_pcrl_checker (.*);

`default_nettype wire

/* test/per_client_rate_limiter_with_block_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the per-client rate limiter table with blocking.
// It holds a queue-fed driver, a scoreboard monitor and a cycle-level-free model of
// the client table. It depends on pcrl_pkg and per_client_rate_limiter_with_block_top.

module per_client_rate_limiter_with_block_top_tb;
  import pcrl_pkg::*;

  localparam int unsigned NUM_CLIENTS     = 256;
  // This limit leaves a wide margin over the slowest stimulus here.
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned REPORT_LINES    = 40;

  // Request codes the block does not define; they must return an all-zero beat.
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;
  // Register index with no register behind it.
  localparam logic [1:0] CFG_SPARE      = 2'd3;
  localparam logic [8:0] TALLY_MAX      = 9'd511;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  client;
    logic [31:0] now;
    logic [31:0] hold;
  } limiter_req_t;

  typedef struct packed {
    logic       accepted;
    logic [8:0] unblocked;
    logic [8:0] removed;
    logic [8:0] blocked;
  } limiter_res_t;

  // Every input starts at a known value, before the first clock edge.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = '0;
  logic [23:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic [2:0]  req_type_i     = '0;
  logic [7:0]  client_i       = '0;
  logic [31:0] now_time_i     = '0;
  logic [31:0] hold_seconds_i = '0;
  logic        out_stall_i    = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        accepted_o;
  logic [8:0]  unblocked_count_o;
  logic [8:0]  removed_count_o;
  logic [8:0]  blocked_count_o;

  per_client_rate_limiter_with_block_top #(
    .CLIENTS(NUM_CLIENTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .client_i         (client_i),
    .now_time_i       (now_time_i),
    .hold_seconds_i   (hold_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .unblocked_count_o(unblocked_count_o),
    .removed_count_o  (removed_count_o),
    .blocked_count_o  (blocked_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model copy of the client table and the three registers.
  bit          tbl_valid   [NUM_CLIENTS];
  bit          tbl_blocked [NUM_CLIENTS];
  logic [20:0] tbl_count   [NUM_CLIENTS];
  logic [31:0] tbl_start   [NUM_CLIENTS];
  logic [31:0] tbl_until   [NUM_CLIENTS];
  logic [19:0] lim_max;
  logic [23:0] lim_window;
  logic [23:0] lim_penalty;

  limiter_req_t pending_reqs[$];
  limiter_res_t expected_results[$];

  int unsigned mismatches    = 0;
  int unsigned beats_checked = 0;
  int unsigned cycle_count   = 0;
  logic [31:0] sim_now       = '0;

  // Idling controls, set by the stimulus thread and read by the two drivers.
  bit          sender_idle_on   = 1'b1;
  bit          receiver_idle_on = 1'b1;
  int unsigned hold_off_asks    = 0;
  int unsigned hold_off_done    = 0;
  int unsigned hold_off_left    = 0;
  int unsigned stall_left       = 0;
  int unsigned send_gap         = 0;
  limiter_req_t next_req;
  limiter_res_t want;

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // Expiry sums clamp at the top of the 32-bit time range instead of wrapping.
  function automatic logic [31:0] sum_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // A clock that reads earlier than the window start counts as no time passed.
  function automatic logic [31:0] elapsed_since(input logic [31:0] now, input logic [31:0] start);
    return (now >= start) ? now - start : 32'd0;
  endfunction

  // An absent entry behaves as all zero; touching it makes it live.
  function automatic void claim_entry(input int unsigned idx);
    if (!tbl_valid[idx]) begin
      tbl_valid[idx]   = 1'b1;
      tbl_blocked[idx] = 1'b0;
      tbl_count[idx]   = '0;
      tbl_start[idx]   = '0;
      tbl_until[idx]   = '0;
    end
  endfunction

  // Lifts a block whose hold time is over and restarts its window.
  function automatic bit lift_block(input int unsigned idx, input logic [31:0] now);
    if (tbl_blocked[idx] && now >= tbl_until[idx]) begin
      tbl_blocked[idx] = 1'b0;
      tbl_count[idx]   = '0;
      tbl_start[idx]   = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic limiter_res_t apply_request(input limiter_req_t r);
    limiter_res_t res;
    int unsigned  idx;
    int unsigned  i;
    logic [31:0]  stale_span;
    res        = '0;
    idx        = r.client;
    stale_span = {7'd0, lim_window, 1'b0};
    case (r.kind)
      REQ_EVENT: begin
        claim_entry(idx);
        void'(lift_block(idx, r.now));
        if (!tbl_blocked[idx]) begin
          if (elapsed_since(r.now, tbl_start[idx]) >= {8'd0, lim_window}) begin
            tbl_start[idx] = r.now;
            tbl_count[idx] = '0;
          end
          if (tbl_count[idx] != COUNT_MAX) tbl_count[idx] = tbl_count[idx] + 1'b1;
          if (tbl_count[idx] > {1'b0, lim_max}) begin
            tbl_blocked[idx] = 1'b1;
            tbl_until[idx]   = sum_sat(r.now, {8'd0, lim_penalty});
          end else begin
            res.accepted = 1'b1;
          end
        end
      end
      REQ_BLOCK: begin
        // Count and window survive a manual block.
        claim_entry(idx);
        tbl_blocked[idx] = 1'b1;
        tbl_until[idx]   = sum_sat(r.now, r.hold);
      end
      REQ_UNBLOCK: begin
        if (tbl_valid[idx]) begin
          tbl_blocked[idx] = 1'b0;
          tbl_count[idx]   = '0;
          tbl_start[idx]   = r.now;
        end
      end
      REQ_SWEEP: begin
        for (i = 0; i < NUM_CLIENTS; i++) begin
          if (tbl_valid[i]) begin
            if (lift_block(i, r.now) && res.unblocked != TALLY_MAX)
              res.unblocked = res.unblocked + 1'b1;
            // An idle entry older than two windows is dropped from the table.
            if (!tbl_blocked[i] && elapsed_since(r.now, tbl_start[i]) >= stale_span) begin
              tbl_valid[i] = 1'b0;
              tbl_count[i] = '0;
              tbl_start[i] = '0;
              tbl_until[i] = '0;
              if (res.removed != TALLY_MAX) res.removed = res.removed + 1'b1;
            end
          end
        end
      end
      REQ_BLOCK_ALL: begin
        for (i = 0; i < NUM_CLIENTS; i++) begin
          if (tbl_valid[i]) begin
            tbl_blocked[i] = 1'b1;
            tbl_until[i]   = sum_sat(r.now, YEAR_SECONDS);
            if (res.blocked != TALLY_MAX) res.blocked = res.blocked + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  task automatic queue_req(input logic [2:0] kind, input logic [7:0] client,
                           input logic [31:0] now, input logic [31:0] hold);
    pending_reqs.push_back('{kind: kind, client: client, now: now, hold: hold});
    sim_now = now;
  endtask

  // Random requests. Most events land on a handful of clients so that bursts
  // push them over the limit, into a block, and back out once the block expires.
  task automatic queue_random(input int unsigned count);
    limiter_req_t r;
    int unsigned  pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 74)      r.kind = REQ_EVENT;
      else if (pick < 81) r.kind = REQ_BLOCK;
      else if (pick < 87) r.kind = REQ_UNBLOCK;
      else if (pick < 92) r.kind = REQ_SWEEP;
      else if (pick < 95) r.kind = REQ_BLOCK_ALL;
      else                r.kind = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));

      pick = $urandom_range(0, 99);
      if (pick < 70)      r.client = 8'($urandom_range(0, 7));
      else if (pick < 80) r.client = pick[0] ? 8'hFF : 8'h00;
      else                r.client = 8'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 40)      r.hold = $urandom_range(0, 50);
      else if (pick < 70) r.hold = $urandom_range(0, 1000);
      else if (pick < 90) r.hold = $urandom;
      else                r.hold = 32'hFFFF_FFFF;

      // Time mostly creeps forward; sometimes it leaps past windows or a year,
      // and once in a while it steps back below a window start.
      pick = $urandom_range(0, 99);
      if (pick < 50)      ;
      else if (pick < 80) sim_now = sum_sat(sim_now, $urandom_range(1, 3));
      else if (pick < 92) sim_now = sum_sat(sim_now,
                                            $urandom_range(0, {7'd0, lim_window, 1'b0} + 2));
      else if (pick < 97) sim_now = sum_sat(sim_now, $urandom_range(0, 32'h0200_0000));
      else                sim_now = (sim_now > 63) ? sim_now - $urandom_range(1, 63) : 32'd0;
      r.now = sim_now;
      pending_reqs.push_back(r);
    end
  endtask

  // Blocks until every queued request has gone in and every result beat has come back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Registers only change while the table is idle; the model follows at once.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_EVENTS: lim_max     = data[19:0];
      CFG_WINDOW:     lim_window  = data;
      CFG_PENALTY:    lim_penalty = data;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [8:0] got, input logic [8:0] exp_val);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("%0t: beat %0d: %s is %0d, expected %0d", $time, beats_checked, what, got, exp_val);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pops the request queue, holds a beat while the block stalls,
  // and runs the model on each beat at the edge where it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(apply_request({req_type_i, client_i, now_time_i,
                                                  hold_seconds_i}));
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid_i     <= 1'b1;
          req_type_i     <= next_req.kind;
          client_i       <= next_req.client;
          now_time_i     <= next_req.now;
          hold_seconds_i <= next_req.hold;
          send_gap = (sender_idle_on && $urandom_range(0, 99) >= 60) ? idle_length() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: random short and long stalls, plus a long hold-off on request
  // so the output register fills and the block has to stall its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_off_left = 0;
    end else if (hold_off_done != hold_off_asks) begin
      hold_off_done++;
      hold_off_left = HOLD_OFF_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (receiver_idle_on && $urandom_range(0, 99) < 30) begin
      stall_left = idle_length() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each beat taken is checked field by field against the
  // oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (expected_results.size() == 0) begin
        flag_mismatch("unrequested result beat, accepted", {8'd0, accepted_o}, 9'd0);
      end else begin
        want = expected_results.pop_front();
        if (accepted_o !== want.accepted)
          flag_mismatch("accepted", {8'd0, accepted_o}, {8'd0, want.accepted});
        if (unblocked_count_o !== want.unblocked)
          flag_mismatch("unblocked_count", unblocked_count_o, want.unblocked);
        if (removed_count_o !== want.removed)
          flag_mismatch("removed_count", removed_count_o, want.removed);
        if (blocked_count_o !== want.blocked)
          flag_mismatch("blocked_count", blocked_count_o, want.blocked);
      end
    end
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("per_client_rate_limiter_with_block_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned i;
    lim_max     = MAX_EVENTS_RST;
    lim_window  = WINDOW_RST;
    lim_penalty = PENALTY_RST;
    for (i = 0; i < NUM_CLIENTS; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_blocked[i] = 1'b0;
      tbl_count[i]   = '0;
      tbl_start[i]   = '0;
      tbl_until[i]   = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset register values (limit 100, window 60, penalty 300).
    // The block clears its table first; the driver simply waits out the stall.
    queue_req(REQ_EVENT,     8'd0,   32'd0,   32'd0);          // absent entry, first event
    queue_req(REQ_EVENT,     8'd255, 32'd0,   32'hFFFF_FFFF);  // top client, hold ignored
    queue_req(REQ_UNBLOCK,   8'd100, 32'd1,   32'd0);          // unblock of an absent entry
    queue_req(REQ_BLOCK,     8'd1,   32'd2,   32'd0);          // zero hold expires at once
    queue_req(REQ_EVENT,     8'd1,   32'd2,   32'd0);          // expired block lifted, accepted
    queue_req(REQ_BLOCK,     8'd2,   32'd3,   32'hFFFF_FFFF);  // hold sum saturates
    queue_req(REQ_EVENT,     8'd2,   32'd4,   32'd0);          // rejected while blocked
    queue_req(REQ_UNBLOCK,   8'd2,   32'd5,   32'd0);
    queue_req(REQ_EVENT,     8'd2,   32'd5,   32'd0);          // accepted again
    queue_req(REQ_EVENT,     8'd3,   32'd100, 32'd0);          // window ran out, restarts
    queue_req(REQ_EVENT,     8'd3,   32'd50,  32'd0);          // clock below window start
    queue_req(REQ_SWEEP,     8'd0,   32'd60,  32'd0);
    queue_req(REQ_BLOCK,     8'd4,   32'd60,  32'd10);
    queue_req(REQ_SWEEP,     8'd0,   32'd80,  32'd0);          // lifts the expired block
    queue_req(REQ_SWEEP,     8'd0,   32'd400, 32'd0);          // drops stale entries
    queue_req(REQ_EVENT,     8'd5,   32'd400, 32'd0);
    queue_req(REQ_BLOCK_ALL, 8'd0,   32'd401, 32'd0);
    queue_req(REQ_EVENT,     8'd5,   32'd402, 32'd0);          // held by the year-long block
    queue_req(REQ_SWEEP,     8'd0,   32'd403, 32'd0);          // nothing expired yet
    queue_req(REQ_UNBLOCK,   8'd5,   32'd404, 32'd0);
    queue_req(REQ_EVENT,     8'd5,   32'd404, 32'd0);
    queue_req(REQ_RSVD_FIRST, 8'd5,  32'd404, 32'hFFFF_FFFF);  // undefined codes do nothing
    queue_req(3'(REQ_RSVD_FIRST + 3'd1), 8'd255, 32'd404, 32'd7);
    queue_req(REQ_RSVD_LAST, 8'd0,   32'd405, 32'd0);
    wait_drained();

    // Tight limits so bursts trip the penalty; the spare index gets a write too.
    write_reg(CFG_MAX_EVENTS, 24'd3);
    write_reg(CFG_WINDOW,     24'd10);
    write_reg(CFG_PENALTY,    24'd20);
    write_reg(CFG_SPARE,      24'h5A_A5C3);
    queue_random(300);
    // Sender pauses here until every result is back, then the receiver holds
    // off for a long stretch while the sender keeps offering beats.
    wait_drained();
    hold_off_asks++;
    queue_random(300);
    wait_drained();

    // Zero limit, zero window and zero penalty, with no idling on either side.
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    write_reg(CFG_MAX_EVENTS, 24'd0);
    write_reg(CFG_WINDOW,     24'd0);
    write_reg(CFG_PENALTY,    24'd0);
    queue_random(250);
    wait_drained();

    // Largest settings; the upper data bits above the limit register are dropped.
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    write_reg(CFG_MAX_EVENTS, 24'hFF_FFFF);
    write_reg(CFG_WINDOW,     24'hFF_FFFF);
    write_reg(CFG_PENALTY,    24'hFF_FFFF);
    sim_now = 32'h4000_0000;
    queue_random(300);
    wait_drained();

    write_reg(CFG_MAX_EVENTS, 24'd5);
    write_reg(CFG_WINDOW,     24'd20);
    write_reg(CFG_PENALTY,    24'd40);
    sim_now = 32'h9000_0000;
    queue_random(200);
    hold_off_asks++;
    queue_random(250);
    wait_drained();

    // Near the top of the time range the penalty and year-long expiry sums saturate.
    write_reg(CFG_MAX_EVENTS, 24'd2);
    write_reg(CFG_WINDOW,     24'd3);
    write_reg(CFG_PENALTY,    24'hFF_FFFF);
    sim_now = 32'hFFFF_FF00;
    queue_random(180);
    wait_drained();

    // Give a stray extra beat time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("per_client_rate_limiter_with_block_top_tb: PASS");
    end else begin
      $display("per_client_rate_limiter_with_block_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/pcrl_pkg.sv
sv/pcrl_ram.sv
sv/per_client_rate_limiter_with_block_top.sv
sv/pcrl_checker.sv
test/per_client_rate_limiter_with_block_top_tb.sv
